FILE: src/pcrs_pkg.sv
// Shared types and constants for the preamp control record scheduler.
// Used by the controller, the datapath and the top level.
package pcrs_pkg;

	localparam logic [1:0] FUNC_SET    = 2'd0;
	localparam logic [1:0] FUNC_ARM    = 2'd1;
	localparam logic [1:0] FUNC_FRAME  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] PARAM_PHANTOM = 2'd0;
	localparam logic [1:0] PARAM_PAD     = 2'd1;
	localparam logic [1:0] PARAM_SENS    = 2'd2;

	localparam logic [1:0] CFG_RESWEEP  = 2'd0;
	localparam logic [1:0] CFG_STRIDE   = 2'd1;
	localparam logic [1:0] CFG_SENS_MAX = 2'd2;

	localparam logic [7:0] DEF_SENS = 8'h20;
	localparam logic [7:0] BOOL_MAX = 8'h01;

	typedef struct packed {
		logic load;
		logic do_set;
		logic do_arm;
		logic scan_clr;
		logic scan_step;
		logic dirty_take;
		logic delay_dec;
		logic rep_step;
		logic rep_take;
		logic rep_end;
		logic silence;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       active;
		logic       dirty_hit;
		logic       scan_last;
		logic       rep_pending;
		logic       delay_zero;
		logic       cursor_done;
		logic       cell_take;
	} sts_t;

endpackage

FILE: src/pcrs_ctrl.sv
// Controller state machine of the preamp control record scheduler.
// Depends on pcrs_pkg for the command and status structs.
module pcrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pcrs_pkg::sts_t    sts,
	output pcrs_pkg::cmd_t    cmd
);
	import pcrs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_DSCAN = 3'd2;
	localparam logic [2:0] S_REP   = 3'd3;
	localparam logic [2:0] S_RSCAN = 3'd4;
	localparam logic [2:0] S_SIL   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_v_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_FIN;
				case (sts.func)
					FUNC_SET: cmd.do_set = 1'b1;
					FUNC_ARM: cmd.do_arm = 1'b1;
					FUNC_FRAME: begin
						if (sts.active) begin
							cmd.scan_clr = 1'b1;
							state_nxt    = S_DSCAN;
						end
					end
					default: ;
				endcase
			end
			S_DSCAN: begin
				if (sts.dirty_hit) begin
					cmd.dirty_take = 1'b1;
					state_nxt      = S_FIN;
				end else if (sts.scan_last) begin
					state_nxt = S_REP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REP: begin
				if (!sts.rep_pending) begin
					state_nxt = S_SIL;
				end else if (!sts.delay_zero) begin
					cmd.delay_dec = 1'b1;
					state_nxt     = S_FIN;
				end else begin
					state_nxt = S_RSCAN;
				end
			end
			S_RSCAN: begin
				if (sts.cursor_done) begin
					cmd.rep_end = 1'b1;
					state_nxt   = S_SIL;
				end else if (sts.cell_take) begin
					cmd.rep_take = 1'b1;
					state_nxt    = S_FIN;
				end else begin
					cmd.rep_step = 1'b1;
				end
			end
			S_SIL: begin
				cmd.silence = 1'b1;
				state_nxt   = S_FIN;
			end
			S_FIN: begin
				if (!out_v_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_v_q;

endmodule

FILE: src/pcrs_dp.sv
// Datapath of the preamp control record scheduler: cell table, replay state,
// silence counter and result registers. Depends on pcrs_pkg.
module pcrs_dp #(
	parameter int CHANNELS = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pcrs_pkg::cmd_t    cmd,
	output pcrs_pkg::sts_t    sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [1:0]        func,
	input  logic [7:0]        chan,
	input  logic [7:0]        param_sel,
	input  logic [7:0]        cell_value_in,
	input  logic [7:0]        scene_base_in,
	input  logic [7:0]        scene_width_in,
	output logic              emitted,
	output logic [5:0]        out_chan,
	output logic [1:0]        out_param,
	output logic [7:0]        out_value,
	output logic              status
);
	import pcrs_pkg::*;

	localparam int         NCELL = CHANNELS * 3;
	localparam int         IW    = $clog2(NCELL);
	localparam logic [8:0] CH9   = 9'(CHANNELS);

	logic [31:0] resweep_q;
	logic [7:0]  stride_q;
	logic [7:0]  sens_max_q;

	logic [1:0]  func_q;
	logic [7:0]  chan_q, psel_q, val_q, base_q, width_q;

	logic [7:0]       mem [NCELL];
	logic [7:0]       rdata_q;
	logic [NCELL-1:0] set_q;
	logic [NCELL-1:0] dirty_q;

	logic        ever_q;
	logic [5:0]  rfirst_q;
	logic [6:0]  rcnt_q;
	logic [6:0]  roff_q;
	logic [1:0]  rpar_q;
	logic [7:0]  rdelay_q;
	logic        ronly_q;
	logic [5:0]  afirst_q;
	logic [6:0]  acnt_q;
	logic [31:0] sil_q;

	logic [IW-1:0] sidx_q;
	logic [5:0]    schan_q;
	logic [1:0]    spar_q;

	logic       res_emit_q, res_status_q, res_mem_q;
	logic [5:0] res_chan_q;
	logic [1:0] res_par_q;
	logic [7:0] res_def_q;

	logic          is_bool, is_sens, value_ok, set_ok;
	logic [9:0]    set_k;
	logic [IW-1:0] set_i;
	logic          arm_ok;
	logic [8:0]    arm_sum, arm_cnt;
	logic [5:0]    rc;
	logic [7:0]    rk;
	logic [IW-1:0] rk_i;
	logic          have, rlast;
	logic [31:0]   sil_next;

	always_comb begin
		is_bool  = (psel_q == {6'd0, PARAM_PHANTOM}) || (psel_q == {6'd0, PARAM_PAD});
		is_sens  = (psel_q == {6'd0, PARAM_SENS});
		value_ok = (is_bool && (val_q <= BOOL_MAX)) || (is_sens && (val_q <= sens_max_q));
		set_ok   = ({1'b0, chan_q} < CH9) && value_ok;
		set_k    = {1'b0, chan_q, 1'b0} + {2'b0, chan_q} + {2'b0, psel_q};
		set_i    = set_k[IW-1:0];

		arm_ok  = (width_q != 8'd0) && ({1'b0, base_q} < CH9);
		arm_sum = {1'b0, base_q} + {1'b0, width_q};
		arm_cnt = (arm_sum > CH9) ? (CH9 - {1'b0, base_q}) : {1'b0, width_q};

		rc    = rfirst_q + roff_q[5:0];
		rk    = {1'b0, rc, 1'b0} + {2'b0, rc} + {6'b0, rpar_q};
		rk_i  = rk[IW-1:0];
		have  = set_q[rk_i];
		rlast = (roff_q == (rcnt_q - 7'd1)) && (rpar_q == PARAM_SENS);

		sil_next = sil_q + 32'd1;

		sts.func        = func_q;
		sts.active      = ever_q || (rcnt_q != 7'd0);
		sts.dirty_hit   = dirty_q[sidx_q];
		sts.scan_last   = (sidx_q == IW'(NCELL - 1));
		sts.rep_pending = (rcnt_q != 7'd0);
		sts.delay_zero  = (rdelay_q == 8'd0);
		sts.cursor_done = (roff_q >= rcnt_q);
		sts.cell_take   = !ronly_q || have;
	end

	// Cell value store; a replay may latch a cell whose set mark is down, but that value is not used in the record.
	always_ff @(posedge clk) begin
		if (cmd.do_set && set_ok) begin
			mem[set_i] <= val_q;
		end
		if (cmd.dirty_take) begin
			rdata_q <= mem[sidx_q];
		end else if (cmd.rep_take) begin
			rdata_q <= mem[rk_i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			chan_q  <= chan;
			psel_q  <= param_sel;
			val_q   <= cell_value_in;
			base_q  <= scene_base_in;
			width_q <= scene_width_in;
		end
		if (cmd.load) begin
			res_emit_q   <= 1'b0;
			res_status_q <= 1'b0;
			res_mem_q    <= 1'b0;
			res_chan_q   <= 6'd0;
			res_par_q    <= 2'd0;
			res_def_q    <= 8'd0;
		end
		if (cmd.do_set) begin
			res_status_q <= !set_ok;
		end
		if (cmd.dirty_take) begin
			res_emit_q <= 1'b1;
			res_mem_q  <= 1'b1;
			res_chan_q <= schan_q;
			res_par_q  <= spar_q;
		end
		if (cmd.rep_take) begin
			res_emit_q <= 1'b1;
			res_mem_q  <= have;
			res_chan_q <= rc;
			res_par_q  <= rpar_q;
			res_def_q  <= (rpar_q == PARAM_SENS) ? DEF_SENS : 8'd0;
		end
		if (cmd.out_load) begin
			emitted   <= res_emit_q;
			out_chan  <= res_chan_q;
			out_param <= res_par_q;
			out_value <= !res_emit_q ? 8'd0 : (res_mem_q ? rdata_q : res_def_q);
			status    <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resweep_q  <= '0;
			stride_q   <= 8'd1;
			sens_max_q <= 8'd255;
			set_q      <= '0;
			dirty_q    <= '0;
			ever_q     <= 1'b0;
			rfirst_q   <= '0;
			rcnt_q     <= '0;
			roff_q     <= '0;
			rpar_q     <= '0;
			rdelay_q   <= '0;
			ronly_q    <= 1'b0;
			afirst_q   <= '0;
			acnt_q     <= '0;
			sil_q      <= '0;
			sidx_q     <= '0;
			schan_q    <= '0;
			spar_q     <= '0;
		end else begin
			if (cmd.do_set && set_ok) begin
				set_q[set_i]   <= 1'b1;
				dirty_q[set_i] <= 1'b1;
				ever_q         <= 1'b1;
			end
			if (cmd.do_arm && arm_ok) begin
				rfirst_q <= base_q[5:0];
				rcnt_q   <= arm_cnt[6:0];
				roff_q   <= '0;
				rpar_q   <= '0;
				rdelay_q <= '0;
				ronly_q  <= 1'b0;
				afirst_q <= base_q[5:0];
				acnt_q   <= arm_cnt[6:0];
				sil_q    <= '0;
			end
			if (cmd.scan_clr) begin
				sidx_q  <= '0;
				schan_q <= '0;
				spar_q  <= '0;
			end
			if (cmd.scan_step) begin
				sidx_q <= sidx_q + IW'(1);
				if (spar_q == PARAM_SENS) begin
					spar_q  <= PARAM_PHANTOM;
					schan_q <= schan_q + 6'd1;
				end else begin
					spar_q <= spar_q + 2'd1;
				end
			end
			if (cmd.dirty_take) begin
				dirty_q[sidx_q] <= 1'b0;
				sil_q           <= '0;
			end
			if (cmd.delay_dec) begin
				rdelay_q <= rdelay_q - 8'd1;
			end
			if (cmd.rep_step || cmd.rep_take) begin
				if (rpar_q == PARAM_SENS) begin
					rpar_q <= PARAM_PHANTOM;
					roff_q <= roff_q + 7'd1;
				end else begin
					rpar_q <= rpar_q + 2'd1;
				end
			end
			if (cmd.rep_take) begin
				sil_q <= '0;
				if (rlast) begin
					rcnt_q <= '0;
				end else begin
					rdelay_q <= (stride_q == 8'd0) ? 8'd0 : stride_q - 8'd1;
				end
			end
			if (cmd.rep_end) begin
				rcnt_q <= '0;
			end
			if (cmd.silence && (resweep_q != 32'd0) && (acnt_q != 7'd0)) begin
				if (sil_next >= resweep_q) begin
					sil_q    <= '0;
					rfirst_q <= afirst_q;
					rcnt_q   <= acnt_q;
					roff_q   <= '0;
					rpar_q   <= '0;
					rdelay_q <= '0;
					ronly_q  <= 1'b1;
				end else begin
					sil_q <= sil_next;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RESWEEP: begin
						resweep_q <= cfg_data;
						sil_q     <= '0;
					end
					CFG_STRIDE:   stride_q   <= cfg_data[7:0];
					CFG_SENS_MAX: sens_max_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: src/preamp_control_record_scheduler.sv
// Preamp control record scheduler: keeps phantom, pad and sensitivity per
// channel and emits at most one control record per frame slot item. Set, arm
// and unknown items pass through the execute and finish states to the result,
// and the next item is taken once the controller is back in idle. A frame
// slot walks the dirty marks one cell per cycle and then, if a replay is due,
// steps the replay cursor one cell per cycle. The finished result sits in an
// output register, so the next item is taken while it waits.
module preamp_control_record_scheduler #(
	parameter int CHANNELS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  chan,
	input  logic [7:0]  param_sel,
	input  logic [7:0]  cell_value_in,
	input  logic [7:0]  scene_base_in,
	input  logic [7:0]  scene_width_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        emitted,
	output logic [5:0]  out_chan,
	output logic [1:0]  out_param,
	output logic [7:0]  out_value,
	output logic        status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import pcrs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pcrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcrs_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.chan           (chan),
		.param_sel      (param_sel),
		.cell_value_in  (cell_value_in),
		.scene_base_in  (scene_base_in),
		.scene_width_in (scene_width_in),
		.emitted        (emitted),
		.out_chan       (out_chan),
		.out_param      (out_param),
		.out_value      (out_value),
		.status         (status)
	);

`ifndef NO_ASSERTIONS
	// A rejected set never carries a record.
	a_no_emit_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(status && emitted))
		else $error("record emitted with reject status");

	// An emitted record names a real cell.
	a_record_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && emitted) |-> ((out_param <= PARAM_SENS) && ({26'd0, out_chan} < CHANNELS)))
		else $error("emitted record out of range");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while busy");

	// A result is only produced after work, never straight from idle.
	a_load_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready)
		else $error("result loaded while idle");
`endif

endmodule

FILE: sim/tb_preamp_control_record_scheduler.sv
// Testbench for the preamp control record scheduler: directed and random items
// checked against a behavioral predictor held in a small scoreboard class.
// Depends on pcrs_pkg and the preamp_control_record_scheduler RTL.
`timescale 1ns / 1ps

module tb_preamp_control_record_scheduler;
	import pcrs_pkg::*;

	localparam int NCH = 40;
	localparam int NCELLS = NCH * 3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic       emitted;
		logic [5:0] chan;
		logic [1:0] param;
		logic [7:0] value;
		logic       status;
	} record_t;

	int err_count = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	class record_scoreboard;
		logic [31:0] resweep_len;
		logic [7:0]  sweep_stride;
		logic [7:0]  sens_max;
		logic [7:0]  values[NCELLS];
		bit          set_mark[NCELLS];
		bit          dirty_mark[NCELLS];
		bit          ever_active;
		int unsigned rep_first, rep_count, rep_cursor, rep_delay;
		bit          rep_only_set;
		int unsigned armed_first, armed_count;
		logic [31:0] silence;
		record_t     pending[$];

		function void clear();
			resweep_len = 0; sweep_stride = 1; sens_max = 255;
			foreach (values[i]) begin
				values[i] = 0; set_mark[i] = 0; dirty_mark[i] = 0;
			end
			ever_active = 0; rep_first = 0; rep_count = 0; rep_cursor = 0;
			rep_delay = 0; rep_only_set = 0; armed_first = 0; armed_count = 0;
			silence = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			if (idx == CFG_RESWEEP) begin
				resweep_len = data; silence = 0;
			end else if (idx == CFG_STRIDE) begin
				sweep_stride = data[7:0];
			end else if (idx == CFG_SENS_MAX) begin
				sens_max = data[7:0];
			end
		endfunction

		function void run_frame(ref record_t r);
			int unsigned total, c, p, k;
			bit have;
			if (!ever_active && rep_count == 0) return;
			for (int i = 0; i < NCELLS; i++) begin
				if (dirty_mark[i]) begin
					dirty_mark[i] = 0;
					r.emitted = 1; r.chan = 6'(i / 3); r.param = 2'(i % 3);
					r.value = values[i];
					silence = 0;
					return;
				end
			end
			if (rep_count != 0) begin
				total = rep_count * 3;
				if (rep_delay > 0) begin
					rep_delay--;
					return;
				end
				while (rep_cursor < total) begin
					c = rep_first + rep_cursor / 3;
					p = rep_cursor % 3;
					k = c * 3 + p;
					have = (c < NCH) && set_mark[k];
					rep_cursor++;
					if (rep_only_set && !have) continue;
					r.emitted = 1; r.chan = 6'(c); r.param = 2'(p);
					r.value = have ? values[k] : (p == PARAM_SENS ? DEF_SENS : 8'd0);
					if (rep_cursor >= total) rep_count = 0;
					else rep_delay = (sweep_stride == 0) ? 0 : sweep_stride - 1;
					silence = 0;
					return;
				end
				rep_count = 0;
			end
			if (resweep_len != 0 && armed_count != 0) begin
				silence++;
				if (silence >= resweep_len) begin
					silence = 0; rep_first = armed_first; rep_count = armed_count;
					rep_cursor = 0; rep_delay = 0; rep_only_set = 1;
				end
			end
		endfunction

		function void note_item(logic [1:0] f, logic [7:0] ch, logic [7:0] ps,
				logic [7:0] v, logic [7:0] base, logic [7:0] width);
			record_t r;
			bit ok;
			int unsigned w;
			r = '0;
			if (f == FUNC_SET) begin
				if (ps == PARAM_PHANTOM || ps == PARAM_PAD) ok = (v <= BOOL_MAX);
				else if (ps == PARAM_SENS) ok = (v <= sens_max);
				else ok = 0;
				if (ch >= NCH || !ok) begin
					r.status = 1;
				end else begin
					values[ch * 3 + ps] = v;
					set_mark[ch * 3 + ps] = 1;
					dirty_mark[ch * 3 + ps] = 1;
					ever_active = 1;
				end
			end else if (f == FUNC_ARM) begin
				if (width != 0 && base < NCH) begin
					w = width;
					if (base + w > NCH) w = NCH - base;
					rep_first = base; rep_count = w; rep_cursor = 0; rep_delay = 0;
					rep_only_set = 0; armed_first = base; armed_count = w; silence = 0;
				end
			end else if (f == FUNC_FRAME) begin
				run_frame(r);
			end
			pending.push_back(r);
		endfunction

		task check_record(record_t got);
			record_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.emitted !== want.emitted)
				report_mismatch("emitted", got.emitted, want.emitted);
			if (got.chan !== want.chan) report_mismatch("out_chan", got.chan, want.chan);
			if (got.param !== want.param) report_mismatch("out_param", got.param, want.param);
			if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [1:0] func = 0;
	logic [7:0] chan = 0, param_sel = 0, cell_value_in = 0, scene_base_in = 0;
	logic [7:0] scene_width_in = 0;
	logic emitted, status;
	logic [5:0] out_chan;
	logic [1:0] out_param;
	logic [7:0] out_value;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	bit quiet = 0;
	int cycles = 0;

	record_scoreboard board = new();

	preamp_control_record_scheduler #(.CHANNELS(NCH)) DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("preamp_control_record_scheduler regression: fail");
			$finish;
		end
	end

	// Results are checked at the rising edge where they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_record('{emitted, out_chan, out_param, out_value, status});
	end

	// The result side stalls in random bursts, except once quiet is set.
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1;
			n = $urandom_range(1, 30);
			repeat (n) @(negedge clk);
			if (!quiet) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	// The valid line stays up after an item is taken until the next item or an
	// idle burst replaces it; meanwhile the block is busy with the item it took.
	task automatic send_item(input logic [1:0] f, input logic [7:0] ch, input logic [7:0] ps,
			input logic [7:0] v, input logic [7:0] base, input logic [7:0] width);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1;
		func <= f; chan <= ch; param_sel <= ps; cell_value_in <= v;
		scene_base_in <= base; scene_width_in <= width;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_item(f, ch, ps, v, base, width);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_item(input int set_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < set_pct)
			send_item(FUNC_SET, 8'($urandom_range(0, 44)),
				8'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 2)),
				8'(($urandom_range(0, 1)) ? $urandom_range(0, 2) : $urandom),
				8'($urandom), 8'($urandom));
		else if (r < set_pct + 8)
			send_item(FUNC_ARM, 8'($urandom), 8'($urandom), 8'($urandom),
				8'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 39)),
				8'(($urandom_range(0, 1)) ? $urandom_range(0, 6) : $urandom));
		else if (r < set_pct + 10)
			send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		else
			send_item(FUNC_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
	endtask

	initial begin
		board.clear();
		repeat (8) @(negedge clk);
		arst_n <= 1;
		repeat (2) @(negedge clk);

		// Directed: idle frame, rejects, extremes, arms, unknown func, defaults.
		send_item(FUNC_FRAME, 0, 0, 0, 0, 0);
		send_item(FUNC_SET, 40, PARAM_PAD, 1, 0, 0);
		send_item(FUNC_SET, 255, PARAM_PAD, 0, 0, 0);
		send_item(FUNC_SET, 3, 8'd3, 0, 0, 0);
		send_item(FUNC_SET, 3, 8'hff, 0, 0, 0);
		send_item(FUNC_SET, 3, PARAM_PHANTOM, 2, 0, 0);
		send_item(FUNC_SET, 3, PARAM_PAD, 8'hff, 0, 0);
		send_item(FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		send_item(FUNC_ARM, 0, 0, 0, 40, 5);
		send_item(FUNC_ARM, 0, 0, 0, 255, 255);
		send_item(FUNC_ARM, 0, 0, 0, 10, 0);
		send_item(FUNC_ARM, 0, 0, 0, 37, 255);
		repeat (6) send_item(FUNC_FRAME, 0, 0, 0, 0, 0);
		send_item(FUNC_SET, 39, PARAM_SENS, 8'hff, 0, 0);
		send_item(FUNC_SET, 0, PARAM_PHANTOM, 1, 0, 0);
		send_item(FUNC_SET, 0, PARAM_PAD, 0, 0, 0);
		repeat (5) send_item(FUNC_FRAME, 0, 0, 0, 0, 0);
		drain();

		// Phases of register settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_RESWEEP, 3);
					write_reg(CFG_STRIDE, 0);
					write_reg(CFG_SENS_MAX, 0);
				end
				1: begin
					write_reg(CFG_RESWEEP, 32'hffffffff);
					write_reg(CFG_STRIDE, 255);
					write_reg(CFG_SENS_MAX, 255);
				end
				2: begin
					write_reg(CFG_RESWEEP, 1);
					write_reg(CFG_STRIDE, 1);
					write_reg(CFG_SENS_MAX, 8'h80);
				end
				3: begin
					write_reg(CFG_RESWEEP, 0);
					write_reg(CFG_STRIDE, 2);
					write_reg(CFG_SENS_MAX, 8'h7f);
				end
				4: begin
					write_reg(CFG_RESWEEP, $urandom_range(1, 20));
					write_reg(CFG_STRIDE, $urandom_range(1, 4));
					write_reg(CFG_SENS_MAX, $urandom);
				end
				default: begin
					write_reg(CFG_RESWEEP, 5);
					write_reg(CFG_STRIDE, 1);
					write_reg(CFG_SENS_MAX, 8'h40);
				end
			endcase
			if (ph == 5) quiet = 1;
			for (int n = 0; n < 205; n++) begin
				random_item(ph == 1 ? 15 : 30);
				// Hold the sender back once until everything outstanding has come.
				if (ph == 2 && n == 100) begin
					in_valid <= 0;
					while (board.pending.size() != 0) @(posedge clk);
					@(negedge clk);
				end
			end
			drain();
		end

		if (err_count == 0)
			$display("preamp_control_record_scheduler regression: pass");
		else
			$display("preamp_control_record_scheduler regression: fail");
		$finish;
	end
endmodule

FILE: preamp_control_record_scheduler.f
src/pcrs_pkg.sv
src/pcrs_ctrl.sv
src/pcrs_dp.sv
src/preamp_control_record_scheduler.sv
sim/tb_preamp_control_record_scheduler.sv
